// ===== hdl/tsrc_pkg.sv =====
// shared types and constants for the timed sample ring capture block
`timescale 1ns / 1ps

package tsrc_pkg;

  localparam int CMD_W    = 2;
  localparam int TIME_W   = 32;
  localparam int OFFSET_W = 9;

  // low nibble and high part of the read offset, reduced through small tables
  localparam int OFF_LO_W = 4;
  localparam int OFF_HI_W = OFFSET_W - OFF_LO_W;

  localparam logic [TIME_W-1:0] INTERVAL_RESET = 32'd1000;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_BEGIN = 2'd3
  } cmd_t;

endpackage

// ===== hdl/tsrc_ram.sv =====
// single-port-write, single-port-read sample memory with registered read data
`timescale 1ns / 1ps

module tsrc_ram #(
  parameter int DEPTH = 512,
  parameter int WIDTH = 10
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hdl/timed_sample_ring_capture.sv =====
// top level of the timed sample ring capture block
// Latency: out_valid rises in the cycle after start is accepted; a read returns registered ram data.
// Throughput: one command per cycle unless busy; only sample-taking ticks and reads access the ram.
// Reset (rst_n low, synchronous) clears pointer, count, timestamp and interval (to 1000);
// busy stays high for the first cycle after reset; unwritten entries read as zero through the
// pointer and a wrap flag, so no clearing pass. The receiver cannot stall: results last one cycle.
`timescale 1ns / 1ps

module timed_sample_ring_capture #(
  parameter int DEPTH       = 512,
  parameter int SAMPLE_BITS = 10
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // command channel
  input  logic                                start,
  output logic                                busy,
  input  logic [tsrc_pkg::CMD_W-1:0]          in_command,
  input  logic [tsrc_pkg::TIME_W-1:0]         in_now_us,
  input  logic [SAMPLE_BITS-1:0]              in_adc_sample,
  input  logic [tsrc_pkg::OFFSET_W-1:0]       in_read_offset,
  // result channel
  output logic                                out_valid,
  output logic [SAMPLE_BITS-1:0]              out_read_data,
  output logic [$clog2(DEPTH+1)-1:0]          out_valid_count,
  output logic [SAMPLE_BITS-1:0]              out_latest_sample,
  output logic                                out_sample_taken,
  // interval register write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tsrc_pkg::TIME_W-1:0]         cfg_data
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W:0]   DEPTH_P = (PTR_W + 1)'(DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  localparam int OFF_LO_N = 1 << tsrc_pkg::OFF_LO_W;
  localparam int OFF_HI_N = 1 << tsrc_pkg::OFF_HI_W;

  tsrc_pkg::cmd_t cmd;

  // control state
  logic                        init_r;
  logic [tsrc_pkg::TIME_W-1:0] interval_r;
  logic [tsrc_pkg::TIME_W-1:0] last_time_r, last_time_nxt;
  logic [PTR_W-1:0]            wp_r, wp_nxt;
  logic [PTR_W-1:0]            oldest_r, oldest_nxt;
  logic [CNT_W-1:0]            count_r, count_nxt;
  logic                        wrapped_r, wrapped_nxt;
  logic [SAMPLE_BITS-1:0]      latest_r, latest_nxt;

  // result registers
  logic                        out_valid_r;
  logic                        out_rd_sel_r;
  logic                        out_taken_r;
  logic [CNT_W-1:0]            out_count_r;
  logic [SAMPLE_BITS-1:0]      out_latest_r;

  logic                        accept;
  logic [tsrc_pkg::TIME_W-1:0] elapsed;
  logic                        take;
  logic [PTR_W-1:0]            wp_inc;
  logic                        is_read;
  logic                        rd_written;

  // offset reduction tables and address math
  logic [PTR_W-1:0]            off_hi_tbl [OFF_HI_N];
  logic [PTR_W-1:0]            off_lo_tbl [OFF_LO_N];
  logic [PTR_W:0]              off_sum;
  logic [PTR_W-1:0]            off_red;
  logic [PTR_W:0]              addr_sum;
  logic [PTR_W-1:0]            rd_addr;
  logic [SAMPLE_BITS-1:0]      ram_q;

  assign cmd       = tsrc_pkg::cmd_t'(in_command);
  assign accept    = start && !init_r;
  assign busy      = init_r;
  assign cfg_ready = !init_r;

  // constant tables: (hi * 16) mod DEPTH and lo mod DEPTH
  for (genvar g = 0; g < OFF_HI_N; g++) begin : g_hi_tbl
    assign off_hi_tbl[g] = PTR_W'((g * OFF_LO_N) % DEPTH);
  end
  for (genvar g = 0; g < OFF_LO_N; g++) begin : g_lo_tbl
    assign off_lo_tbl[g] = PTR_W'(g % DEPTH);
  end

  // read address: (oldest + offset) mod depth
  always_comb begin
    off_sum  = {1'b0, off_hi_tbl[in_read_offset[tsrc_pkg::OFFSET_W-1:tsrc_pkg::OFF_LO_W]]}
             + {1'b0, off_lo_tbl[in_read_offset[tsrc_pkg::OFF_LO_W-1:0]]};
    off_red  = (off_sum >= DEPTH_P) ? PTR_W'(off_sum - DEPTH_P) : off_sum[PTR_W-1:0];
    addr_sum = {1'b0, oldest_r} + {1'b0, off_red};
    rd_addr  = (addr_sum >= DEPTH_P) ? PTR_W'(addr_sum - DEPTH_P) : addr_sum[PTR_W-1:0];
  end

  // an entry holds written data once the pointer has passed it or wrapped
  assign rd_written = wrapped_r || (rd_addr < wp_r);

  // tick decision with wrap-safe elapsed time
  assign elapsed = in_now_us - last_time_r;
  assign take    = accept && (cmd == tsrc_pkg::CMD_TICK) && (elapsed >= interval_r);
  assign is_read = accept && (cmd == tsrc_pkg::CMD_READ);
  assign wp_inc  = (wp_r == PTR_LAST) ? '0 : wp_r + 1'b1;

  // next state per command
  always_comb begin
    last_time_nxt = last_time_r;
    wp_nxt        = wp_r;
    oldest_nxt    = oldest_r;
    count_nxt     = count_r;
    wrapped_nxt   = wrapped_r;
    latest_nxt    = latest_r;
    if (accept) begin
      unique case (cmd)
        tsrc_pkg::CMD_TICK: begin
          if (take) begin
            last_time_nxt = in_now_us;
            wp_nxt        = wp_inc;
            latest_nxt    = in_adc_sample;
            if (wp_r == PTR_LAST) begin
              wrapped_nxt = 1'b1;
            end
            if (count_r == CNT_FULL) begin
              oldest_nxt = wp_inc;
            end else begin
              count_nxt = count_r + 1'b1;
            end
          end
        end
        tsrc_pkg::CMD_READ: begin
        end
        tsrc_pkg::CMD_CLEAR: begin
          count_nxt  = '0;
          oldest_nxt = wp_r;
        end
        tsrc_pkg::CMD_BEGIN: begin
          last_time_nxt = in_now_us;
        end
        default: begin
        end
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_r      <= 1'b1;
      interval_r  <= tsrc_pkg::INTERVAL_RESET;
      last_time_r <= '0;
      wp_r        <= '0;
      oldest_r    <= '0;
      count_r     <= '0;
      wrapped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      init_r      <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        interval_r <= cfg_data;
      end
      last_time_r <= last_time_nxt;
      wp_r        <= wp_nxt;
      oldest_r    <= oldest_nxt;
      count_r     <= count_nxt;
      wrapped_r   <= wrapped_nxt;
      out_valid_r <= accept;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    latest_r <= latest_nxt;
    if (accept) begin
      out_rd_sel_r <= is_read && rd_written;
      out_taken_r  <= take;
      out_count_r  <= count_nxt;
      out_latest_r <= (count_nxt == '0) ? '0 : latest_nxt;
    end
  end

  // sample memory
  tsrc_ram #(
    .DEPTH (DEPTH),
    .WIDTH (SAMPLE_BITS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (take),
    .wr_addr (wp_r),
    .wr_data (in_adc_sample),
    .rd_en   (is_read),
    .rd_addr (rd_addr),
    .rd_data (ram_q)
  );

  // result beat
  assign out_valid         = out_valid_r;
  assign out_read_data     = out_rd_sel_r ? ram_q : '0;
  assign out_valid_count   = out_count_r;
  assign out_latest_sample = out_latest_r;
  assign out_sample_taken  = out_taken_r;

endmodule
